@@ sv/mfd_pkg.sv @@
// Shared types, codes and constants of the multi-format frame deframer.
`timescale 1ns / 1ps
`default_nettype none
package mfd_pkg;

   localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1048576;

   // result kinds
   localparam logic [1:0] RK_PAYLOAD = 2'd0;
   localparam logic [1:0] RK_ACCEPT  = 2'd1;
   localparam logic [1:0] RK_REJECT  = 2'd2;

   // frame kinds
   localparam logic [1:0] FK_RSP = 2'd0;
   localparam logic [1:0] FK_CMD = 2'd1;
   localparam logic [1:0] FK_CPT = 2'd2;

   // error codes
   localparam logic [1:0] ERR_NONE       = 2'd0;
   localparam logic [1:0] ERR_BAD_HEADER = 2'd1;
   localparam logic [1:0] ERR_TOO_LONG   = 2'd2;
   localparam logic [1:0] ERR_BAD_FOOTER = 2'd3;

   // header bytes
   localparam logic [7:0] HDR_A0 = 8'hAA;
   localparam logic [7:0] HDR_A1 = 8'hAB;
   localparam logic [7:0] HDR_A2 = 8'hBA;
   localparam logic [7:0] HDR_A3 = 8'hBB;
   localparam logic [7:0] HDR_E0 = 8'hEE;
   localparam logic [7:0] HDR_E1 = 8'hEF;
   localparam logic [7:0] HDR_E2 = 8'hFE;
   localparam logic [7:0] HDR_E3 = 8'hFF;

   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
   } in_beat_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [7:0]         payload_byte;
      logic [1:0]         frame_kind;
      logic signed [15:0] status_word;
      logic [15:0]        group_or_code;
      logic [15:0]        unit_or_sequence;
      logic [31:0]        payload_length;
      logic [1:0]         error_code;
   } result_type;

   function automatic logic [7:0] footer_byte(input logic [1:0] kind, input logic [1:0] idx);
      logic [7:0] fb;
      fb = 8'h00;
      case (kind)
         FK_RSP: begin
            case (idx)
               2'd0: fb = 8'hFF;
               2'd1: fb = 8'hFE;
               2'd2: fb = 8'hEF;
               default: fb = 8'hEE;
            endcase
         end
         FK_CMD: begin
            case (idx)
               2'd0: fb = 8'hCC;
               2'd1: fb = 8'hCD;
               2'd2: fb = 8'hDC;
               default: fb = 8'hDD;
            endcase
         end
         default: begin
            fb = (idx[1] == 1'b0) ? 8'hEE : 8'h00;
         end
      endcase
      return fb;
   endfunction

   function automatic logic [1:0] footer_last_idx(input logic [1:0] kind);
      return (kind == FK_CPT) ? 2'd1 : 2'd3;
   endfunction

endpackage
`default_nettype wire

@@ sv/mfd_if.sv @@
// Handshake interfaces for the byte input channel and the result channel.
`timescale 1ns / 1ps
`default_nettype none
interface mfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface mfd_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         result_kind;
   logic [7:0]         payload_byte;
   logic [1:0]         frame_kind;
   logic signed [15:0] status_word;
   logic [15:0]        group_or_code;
   logic [15:0]        unit_or_sequence;
   logic [31:0]        payload_length;
   logic [1:0]         error_code;

   modport source (output valid, output result_kind, output payload_byte, output frame_kind,
                   output status_word, output group_or_code, output unit_or_sequence,
                   output payload_length, output error_code, input ready);
   modport sink   (input valid, input result_kind, input payload_byte, input frame_kind,
                   input status_word, input group_or_code, input unit_or_sequence,
                   input payload_length, input error_code, output ready);
endinterface
`default_nettype wire

@@ sv/mfd_in_stage.sv @@
// Input register: holds one received byte until the parser takes it.
`timescale 1ns / 1ps
`default_nettype none
module mfd_in_stage
   import mfd_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   mfd_req_if.sink     req,
   input  wire logic   advance,
   output in_beat_type beat
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       take;

   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req.data_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign beat.valid     = valid_ff;
   assign beat.data_byte = byte_ff;

endmodule
`default_nettype wire

@@ sv/mfd_parser.sv @@
// Frame state machine, field capture, limit register and result register.
`timescale 1ns / 1ps
`default_nettype none
module mfd_parser
   import mfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire in_beat_type beat,
   output logic             advance,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data,
   mfd_rsp_if.source        rsp
);

   typedef enum logic [12:0] {
      ST_IDLE    = 13'h0001,
      ST_A1      = 13'h0002,
      ST_CMD_H2  = 13'h0004,
      ST_CMD_H3  = 13'h0008,
      ST_E1      = 13'h0010,
      ST_RSP_H2  = 13'h0020,
      ST_RSP_H3  = 13'h0040,
      ST_STATUS  = 13'h0080,
      ST_LENGTH  = 13'h0100,
      ST_GROUP   = 13'h0200,
      ST_UNIT    = 13'h0400,
      ST_PAYLOAD = 13'h0800,
      ST_FOOTER  = 13'h1000
   } state_type;

   state_type   state_ff, state_in;
   logic [1:0]  kind_ff, kind_in;
   logic [2:0]  idx_ff, idx_in;
   logic [15:0] status_ff, status_in;
   logic [15:0] group_ff, group_in;
   logic [15:0] unit_ff, unit_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] remain_ff, remain_in;
   logic        mismatch_ff, mismatch_in;
   logic [31:0] max_ff, max_in;

   logic        out_valid_ff, out_valid_in;
   result_type  out_ff, out_in;

   logic        step;
   logic        emit;
   logic        hunt;
   logic        reject;
   logic        field_done;
   logic        to_body;
   logic        foot_mm;
   logic [7:0]  b;
   result_type  res;

   assign advance = !out_valid_ff || rsp.ready;
   assign step    = beat.valid && advance;
   assign b       = beat.data_byte;

   always_comb begin
      max_in = csr_wr_en ? csr_wr_data : max_ff;
   end

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      idx_in      = idx_ff;
      status_in   = status_ff;
      group_in    = group_ff;
      unit_in     = unit_ff;
      length_in   = length_ff;
      remain_in   = remain_ff;
      mismatch_in = mismatch_ff;
      emit        = 1'b0;
      hunt        = 1'b0;
      reject      = 1'b0;
      field_done  = 1'b0;
      to_body     = 1'b0;
      foot_mm     = 1'b0;
      res         = '0;
      if (step) begin
         unique case (state_ff)
            ST_IDLE: begin
               hunt = 1'b1;
            end
            ST_A1: begin
               if (b == HDR_A1) begin
                  state_in = ST_CMD_H2;
               end else if (b == HDR_A0) begin
                  kind_in  = FK_CPT;
                  idx_in   = 3'd0;
                  state_in = ST_GROUP;
               end else begin
                  reject = 1'b1;
               end
            end
            ST_CMD_H2: begin
               if (b == HDR_A2) state_in = ST_CMD_H3;
               else reject = 1'b1;
            end
            ST_CMD_H3: begin
               if (b == HDR_A3) begin
                  idx_in   = 3'd0;
                  state_in = ST_LENGTH;
               end else begin
                  reject = 1'b1;
               end
            end
            ST_E1: begin
               if (b == HDR_E1) state_in = ST_RSP_H2;
               else reject = 1'b1;
            end
            ST_RSP_H2: begin
               if (b == HDR_E2) state_in = ST_RSP_H3;
               else reject = 1'b1;
            end
            ST_RSP_H3: begin
               if (b == HDR_E3) begin
                  idx_in   = 3'd0;
                  state_in = ST_STATUS;
               end else begin
                  reject = 1'b1;
               end
            end
            ST_STATUS, ST_LENGTH, ST_GROUP, ST_UNIT: begin
               case (state_ff)
                  ST_STATUS: begin
                     if (idx_ff[0]) status_in[15:8] = b;
                     else status_in[7:0] = b;
                  end
                  ST_LENGTH: begin
                     case (idx_ff[1:0])
                        2'd0: length_in[7:0]   = b;
                        2'd1: length_in[15:8]  = b;
                        2'd2: length_in[23:16] = b;
                        default: length_in[31:24] = b;
                     endcase
                  end
                  ST_GROUP: begin
                     if (idx_ff[0]) group_in[15:8] = b;
                     else group_in[7:0] = b;
                  end
                  default: begin
                     if (idx_ff[0]) unit_in[15:8] = b;
                     else unit_in[7:0] = b;
                  end
               endcase
               field_done = (state_ff == ST_LENGTH) ? (idx_ff[1:0] == 2'd3) : idx_ff[0];
               idx_in     = idx_ff + 3'd1;
               if (field_done) begin
                  idx_in = 3'd0;
                  if (state_ff == ST_LENGTH && length_in > max_ff) begin
                     emit                 = 1'b1;
                     res.result_kind      = RK_REJECT;
                     res.frame_kind       = kind_ff;
                     res.status_word      = (kind_ff == FK_RSP) ? status_in : 16'sd0;
                     res.group_or_code    = group_in;
                     res.unit_or_sequence = unit_in;
                     res.payload_length   = length_in;
                     res.error_code       = ERR_TOO_LONG;
                     state_in             = ST_IDLE;
                  end else begin
                     case (state_ff)
                        ST_STATUS: state_in = ST_LENGTH;
                        ST_LENGTH: begin
                           if (kind_ff == FK_CPT) to_body = 1'b1;
                           else state_in = ST_GROUP;
                        end
                        ST_GROUP: state_in = ST_UNIT;
                        default: begin
                           if (kind_ff == FK_CPT) state_in = ST_LENGTH;
                           else to_body = 1'b1;
                        end
                     endcase
                     if (to_body) begin
                        remain_in   = length_in;
                        mismatch_in = 1'b0;
                        state_in    = (length_in == 32'd0) ? ST_FOOTER : ST_PAYLOAD;
                     end
                  end
               end
            end
            ST_PAYLOAD: begin
               emit             = 1'b1;
               res.result_kind  = RK_PAYLOAD;
               res.payload_byte = b;
               res.frame_kind   = kind_ff;
               remain_in        = remain_ff - 32'd1;
               if (remain_ff == 32'd1) begin
                  idx_in   = 3'd0;
                  state_in = ST_FOOTER;
               end
            end
            ST_FOOTER: begin
               foot_mm     = mismatch_ff || (b != footer_byte(kind_ff, idx_ff[1:0]));
               mismatch_in = foot_mm;
               idx_in      = idx_ff + 3'd1;
               if (idx_ff[1:0] == footer_last_idx(kind_ff)) begin
                  emit                 = 1'b1;
                  res.result_kind      = foot_mm ? RK_REJECT : RK_ACCEPT;
                  res.frame_kind       = kind_ff;
                  res.status_word      = (kind_ff == FK_RSP) ? status_ff : 16'sd0;
                  res.group_or_code    = group_ff;
                  res.unit_or_sequence = unit_ff;
                  res.payload_length   = length_ff;
                  res.error_code       = foot_mm ? ERR_BAD_FOOTER : ERR_NONE;
                  idx_in               = 3'd0;
                  mismatch_in          = 1'b0;
                  state_in             = ST_IDLE;
               end
            end
            default: begin
               hunt = 1'b1;
            end
         endcase

         // header mismatch: reject, then re-examine the byte as a start
         if (reject) begin
            emit            = 1'b1;
            res             = '0;
            res.result_kind = RK_REJECT;
            res.frame_kind  = kind_ff;
            res.error_code  = ERR_BAD_HEADER;
            hunt            = 1'b1;
         end

         if (hunt) begin
            status_in   = 16'd0;
            group_in    = 16'd0;
            unit_in     = 16'd0;
            length_in   = 32'd0;
            remain_in   = 32'd0;
            mismatch_in = 1'b0;
            idx_in      = 3'd0;
            if (b == HDR_A0) begin
               kind_in  = FK_CMD;
               state_in = ST_A1;
            end else if (b == HDR_E0) begin
               kind_in  = FK_RSP;
               state_in = ST_E1;
            end else begin
               kind_in  = FK_RSP;
               state_in = ST_IDLE;
            end
         end
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = step && emit;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= FK_RSP;
         idx_ff       <= 3'd0;
         status_ff    <= 16'd0;
         group_ff     <= 16'd0;
         unit_ff      <= 16'd0;
         length_ff    <= 32'd0;
         remain_ff    <= 32'd0;
         mismatch_ff  <= 1'b0;
         max_ff       <= MAX_PAYLOAD_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         idx_ff       <= idx_in;
         status_ff    <= status_in;
         group_ff     <= group_in;
         unit_ff      <= unit_in;
         length_ff    <= length_in;
         remain_ff    <= remain_in;
         mismatch_ff  <= mismatch_in;
         max_ff       <= max_in;
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.result_kind      = out_ff.result_kind;
   assign rsp.payload_byte     = out_ff.payload_byte;
   assign rsp.frame_kind       = out_ff.frame_kind;
   assign rsp.status_word      = out_ff.status_word;
   assign rsp.group_or_code    = out_ff.group_or_code;
   assign rsp.unit_or_sequence = out_ff.unit_or_sequence;
   assign rsp.payload_length   = out_ff.payload_length;
   assign rsp.error_code       = out_ff.error_code;

endmodule
`default_nettype wire

@@ sv/multi_format_frame_deframer_core.sv @@
// Top level of the multi-format frame deframer.
//
//   channel | direction | handshake          | contents
//   req     | in        | valid/ready        | data_byte, one stream byte
//   rsp     | out       | valid/ready        | payload byte or frame descriptor
//   csr     | in        | csr_wr_en          | csr_wr_data = max_payload_bytes
//
// One byte per cycle sustained while rsp does not stall; a byte's result passes
// through the input register, then the parser and the result register.
// At most one result per byte. Synchronous active-high reset; the limit resets
// to 1048576. A stalled rsp holds its result while one more byte is taken into
// the input register, after which req.ready drops until rsp moves.
`timescale 1ns / 1ps
`default_nettype none
module multi_format_frame_deframer_core
   import mfd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   mfd_req_if.sink          req,
   mfd_rsp_if.source        rsp,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   in_beat_type beat;
   logic        advance;

   mfd_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .advance (advance),
      .beat    (beat)
   );

   mfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .beat        (beat),
      .advance     (advance),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp         (rsp)
   );

endmodule
`default_nettype wire

@@ sv/mfd_checker.sv @@
// Port-level checks of the deframer and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mfd_checker
   import mfd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_result_kind,
   input wire logic [7:0]  rsp_payload_byte,
   input wire logic [31:0] rsp_payload_length,
   input wire logic [1:0]  rsp_error_code
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind)
         && $stable(rsp_payload_byte) && $stable(rsp_payload_length))
      else $error("rsp changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req stalled without rsp stall");

   a_error_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_result_kind == RK_REJECT) == (rsp_error_code != ERR_NONE))
         && !(rsp_result_kind == RK_PAYLOAD && rsp_payload_length != 32'd0))
      else $error("descriptor error code inconsistent");

endmodule

bind multi_format_frame_deframer_core mfd_checker u_mfd_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req.ready),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_result_kind    (rsp.result_kind),
   .rsp_payload_byte   (rsp.payload_byte),
   .rsp_payload_length (rsp.payload_length),
   .rsp_error_code     (rsp.error_code)
);
`default_nettype wire

@@ tb/tb_multi_format_frame_deframer_core.sv @@
// Self-checking testbench of the multi-format frame deframer core.
`timescale 1ns / 1ps
module tb_multi_format_frame_deframer_core;
   import mfd_pkg::*;

   localparam int QUIET_LIMIT      = 5000;
   localparam int DRAIN_LIMIT      = 3000;
   localparam int SETTLE_CYCLES    = 6;
   localparam int SEGMENT_BYTES    = 340;
   localparam int SHOWN_MISMATCHES = 40;

   localparam logic [31:0] RSP_TRAILER = 32'hFFFE_EFEE;
   localparam logic [31:0] CMD_TRAILER = 32'hCCCD_DCDD;
   localparam logic [15:0] CPT_TRAILER = 16'hEEEE;

   typedef enum logic [3:0] {
      S_HUNT, S_SAW_AA, S_CMD_2, S_CMD_3, S_SAW_EE, S_RSP_2, S_RSP_3,
      S_STATUS, S_LENGTH, S_GROUP, S_UNIT, S_DATA, S_TRAILER, S_BODY
   } parse_state_type;

   function automatic logic [7:0] trailer_byte(input logic [1:0] k, input int i);
      case (k)
         FK_RSP:  return RSP_TRAILER[8 * (3 - i) +: 8];
         FK_CMD:  return CMD_TRAILER[8 * (3 - i) +: 8];
         default: return CPT_TRAILER[8 * (1 - i) +: 8];
      endcase
   endfunction

   function automatic int trailer_len(input logic [1:0] k);
      return (k == FK_CPT) ? 2 : 4;
   endfunction

   function automatic logic [15:0] any_word();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Tracks the parser state byte by byte and holds the results still owed.
   class frame_tracker;
      result_type      due_results[$];
      int unsigned     mismatches;
      int unsigned     results_seen;
      logic [31:0]     limit;
      parse_state_type state;
      logic [1:0]      fkind;
      logic [2:0]      byte_no;
      logic [15:0]     cap_status;
      logic [15:0]     cap_group;
      logic [15:0]     cap_unit;
      logic [31:0]     cap_length;
      logic [31:0]     data_left;
      logic            trailer_bad;

      function new();
         limit = MAX_PAYLOAD_RESET;
         mismatches = 0;
         results_seen = 0;
         start_hunt(8'h00);
      endfunction

      function void queue_frame_result(input logic [1:0] rk, input logic [1:0] err);
         result_type r;
         r.result_kind      = rk;
         r.payload_byte     = 8'h00;
         r.frame_kind       = fkind;
         r.status_word      = (fkind == FK_RSP) ? cap_status : 16'h0000;
         r.group_or_code    = cap_group;
         r.unit_or_sequence = cap_unit;
         r.payload_length   = cap_length;
         r.error_code       = err;
         due_results.push_back(r);
      endfunction

      function void start_hunt(input logic [7:0] b);
         cap_status  = '0;
         cap_group   = '0;
         cap_unit    = '0;
         cap_length  = '0;
         data_left   = '0;
         trailer_bad = 1'b0;
         byte_no     = '0;
         if (b == HDR_A0) begin
            fkind = FK_CMD;
            state = S_SAW_AA;
         end else if (b == HDR_E0) begin
            fkind = FK_RSP;
            state = S_SAW_EE;
         end else begin
            fkind = FK_RSP;
            state = S_HUNT;
         end
      endfunction

      // the offending byte gets a second look as a start byte
      function void reject_header(input logic [7:0] b);
         cap_status = '0;
         cap_group  = '0;
         cap_unit   = '0;
         cap_length = '0;
         queue_frame_result(RK_REJECT, ERR_BAD_HEADER);
         start_hunt(b);
      endfunction

      function parse_state_type field_after(input parse_state_type s);
         parse_state_type nxt;
         nxt = S_BODY;
         case (fkind)
            FK_RSP: begin
               if (s == S_STATUS) nxt = S_LENGTH;
               else if (s == S_LENGTH) nxt = S_GROUP;
               else if (s == S_GROUP) nxt = S_UNIT;
            end
            FK_CMD: begin
               if (s == S_LENGTH) nxt = S_GROUP;
               else if (s == S_GROUP) nxt = S_UNIT;
            end
            default: begin
               if (s == S_GROUP) nxt = S_UNIT;
               else if (s == S_UNIT) nxt = S_LENGTH;
            end
         endcase
         return nxt;
      endfunction

      function void take_field(input logic [7:0] b);
         logic [31:0] shifted;
         shifted = {24'h0, b} << (8 * byte_no[1:0]);
         case (state)
            S_STATUS: cap_status |= shifted[15:0];
            S_LENGTH: cap_length |= shifted;
            S_GROUP:  cap_group  |= shifted[15:0];
            default:  cap_unit   |= shifted[15:0];
         endcase
         byte_no++;
         if (byte_no < ((state == S_LENGTH) ? 3'd4 : 3'd2)) return;
         byte_no = '0;
         if (state == S_LENGTH && cap_length > limit) begin
            queue_frame_result(RK_REJECT, ERR_TOO_LONG);
            state = S_HUNT;
            return;
         end
         state = field_after(state);
         if (state == S_BODY) begin
            data_left   = cap_length;
            trailer_bad = 1'b0;
            state = (cap_length == 0) ? S_TRAILER : S_DATA;
         end
      endfunction

      function void take_byte(input logic [7:0] b);
         result_type r;
         case (state)
            S_SAW_AA: begin
               if (b == HDR_A1) begin
                  state = S_CMD_2;
               end else if (b == HDR_A0) begin
                  fkind   = FK_CPT;
                  byte_no = '0;
                  state   = S_GROUP;
               end else begin
                  reject_header(b);
               end
            end
            S_CMD_2: begin
               if (b == HDR_A2) state = S_CMD_3;
               else reject_header(b);
            end
            S_CMD_3: begin
               if (b == HDR_A3) begin
                  byte_no = '0;
                  state   = S_LENGTH;
               end else begin
                  reject_header(b);
               end
            end
            S_SAW_EE: begin
               if (b == HDR_E1) state = S_RSP_2;
               else reject_header(b);
            end
            S_RSP_2: begin
               if (b == HDR_E2) state = S_RSP_3;
               else reject_header(b);
            end
            S_RSP_3: begin
               if (b == HDR_E3) begin
                  byte_no = '0;
                  state   = S_STATUS;
               end else begin
                  reject_header(b);
               end
            end
            S_STATUS, S_LENGTH, S_GROUP, S_UNIT: take_field(b);
            S_DATA: begin
               r = '0;
               r.result_kind  = RK_PAYLOAD;
               r.payload_byte = b;
               r.frame_kind   = fkind;
               due_results.push_back(r);
               data_left--;
               if (data_left == 0) begin
                  byte_no = '0;
                  state   = S_TRAILER;
               end
            end
            S_TRAILER: begin
               if (b != trailer_byte(fkind, byte_no)) trailer_bad = 1'b1;
               byte_no++;
               if (byte_no == trailer_len(fkind)) begin
                  if (trailer_bad) queue_frame_result(RK_REJECT, ERR_BAD_FOOTER);
                  else queue_frame_result(RK_ACCEPT, ERR_NONE);
                  byte_no     = '0;
                  trailer_bad = 1'b0;
                  state       = S_HUNT;
               end
            end
            default: start_hunt(b);
         endcase
      endfunction

      task report(input string what);
         if (mismatches < SHOWN_MISMATCHES) $display("mismatch: %s", what);
         mismatches++;
      endtask

      task compare_field(input string name, input logic [31:0] got, input logic [31:0] want);
         if (got !== want)
            report($sformatf("result %0d %s got %0h want %0h", results_seen, name, got, want));
      endtask

      task match_result(input result_type got);
         result_type want;
         results_seen++;
         if (due_results.size() == 0) begin
            report($sformatf("result %0d kind %0d arrived with nothing expected",
                             results_seen, got.result_kind));
            return;
         end
         want = due_results.pop_front();
         compare_field("result_kind", 32'(got.result_kind), 32'(want.result_kind));
         compare_field("payload_byte", 32'(got.payload_byte), 32'(want.payload_byte));
         compare_field("frame_kind", 32'(got.frame_kind), 32'(want.frame_kind));
         compare_field("status_word", 32'(got.status_word), 32'(want.status_word));
         compare_field("group_or_code", 32'(got.group_or_code), 32'(want.group_or_code));
         compare_field("unit_or_sequence", 32'(got.unit_or_sequence),
                       32'(want.unit_or_sequence));
         compare_field("payload_length", got.payload_length, want.payload_length);
         compare_field("error_code", 32'(got.error_code), 32'(want.error_code));
      endtask

      task flag_leftovers();
         if (due_results.size() != 0)
            report($sformatf("%0d expected results never arrived", due_results.size()));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;
   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   int unsigned bytes_sent = 0;
   int unsigned quiet_cycles = 0;
   frame_tracker book;

   mfd_req_if req_bus();
   mfd_rsp_if rsp_bus();

   multi_format_frame_deframer_core uut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : monitor
      result_type got;
      logic moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_bus.valid && req_bus.ready) begin
            book.take_byte(req_bus.data_byte);
            moved = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.result_kind, rsp_bus.payload_byte, rsp_bus.frame_kind,
                    rsp_bus.status_word, rsp_bus.group_or_code, rsp_bus.unit_or_sequence,
                    rsp_bus.payload_length, rsp_bus.error_code};
            book.match_result(got);
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[multi_format_frame_deframer_core] ERROR");
            $finish;
         end
      end
   end

   // called and returns at a falling edge
   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic send_word(input logic [31:0] value, input int n);
      repeat (n) begin
         send_byte(value[7:0]);
         value = value >> 8;
      end
   endtask

   task automatic send_frame(input logic [1:0] kind);
      logic [7:0]  head [4];
      logic [7:0]  b;
      logic [31:0] len;
      logic [15:0] status_id;
      logic [15:0] grp_word;
      logic [15:0] unit_id;
      int unsigned head_len;
      int unsigned wreck;
      int unsigned pick;
      int unsigned spot;
      wreck     = $urandom_range(99);
      pick      = $urandom_range(99);
      status_id = any_word();
      grp_word  = any_word();
      unit_id   = any_word();
      if (pick < 60) len = $urandom_range(12);
      else if (pick < 70) len = 0;
      else if (pick < 80) len = (book.limit <= 16) ? book.limit : $urandom_range(3);
      else if (pick < 90) len = (book.limit != '1) ? book.limit + 1 : $urandom_range(12);
      else begin
         len = $urandom;
         if (len <= book.limit) len = {28'h0, len[3:0]};
      end
      case (kind)
         FK_RSP: begin
            head = '{HDR_E0, HDR_E1, HDR_E2, HDR_E3};
            head_len = 4;
         end
         FK_CMD: begin
            head = '{HDR_A0, HDR_A1, HDR_A2, HDR_A3};
            head_len = 4;
         end
         default: begin
            head = '{HDR_A0, HDR_A0, 8'h00, 8'h00};
            head_len = 2;
         end
      endcase
      if (wreck < 8) begin
         spot = $urandom_range(head_len - 1, 1);
         head[spot] = 8'($urandom);
         for (int j = 0; j <= spot; j++) send_byte(head[j]);
         return;
      end
      for (int j = 0; j < head_len; j++) send_byte(head[j]);
      if (wreck < 12) return;
      if (kind == FK_RSP) send_word({16'h0, status_id}, 2);
      if (kind == FK_CPT) begin
         send_word({16'h0, grp_word}, 2);
         send_word({16'h0, unit_id}, 2);
      end
      send_word(len, 4);
      if (len > book.limit) return;
      if (kind != FK_CPT) begin
         send_word({16'h0, grp_word}, 2);
         send_word({16'h0, unit_id}, 2);
      end
      repeat (len) send_byte(8'($urandom));
      spot = $urandom_range(trailer_len(kind) - 1);
      for (int j = 0; j < trailer_len(kind); j++) begin
         b = trailer_byte(kind, j);
         if (wreck < 25 && j == spot) b = b ^ 8'($urandom_range(255, 1));
         send_byte(b);
      end
   endtask

   // drain owed results, then give the pipeline time to empty
   task automatic settle();
      int n;
      req_bus.valid <= 1'b0;
      n = 0;
      while (book.due_results.size() != 0 && n < DRAIN_LIMIT) begin
         @(posedge clock);
         n++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      logic [7:0]  opening [27] = '{8'h00, 8'hFF, HDR_A0, 8'h00, HDR_E0, HDR_A0, HDR_A0,
                                    8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                    HDR_E0, HDR_E0, HDR_A0, HDR_A0, 8'h34, 8'h12, 8'h78,
                                    8'h56, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      logic [31:0] limits [5];
      int unsigned idles [5]  = '{0, 86, 0, 29, 0};
      int unsigned stalls [5] = '{0, 0, 86, 29, 0};
      logic [1:0]  kinds [3]  = '{FK_RSP, FK_CMD, FK_CPT};
      book = new();
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      limits = '{MAX_PAYLOAD_RESET, 32'h0000_0000, 32'hFFFF_FFFF,
                 32'($urandom_range(12, 3)), MAX_PAYLOAD_RESET};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int seg = 0; seg < 5; seg++) begin
         if (seg > 0) begin
            settle();
            csr_wr_en   <= 1'b1;
            csr_wr_data <= limits[seg];
            @(posedge clock);
            book.limit = limits[seg];
            @(negedge clock);
            csr_wr_en <= 1'b0;
         end
         idle_pct  = idles[seg];
         stall_pct = stalls[seg];
         if (seg == 0) foreach (opening[i]) send_byte(opening[i]);
         while (bytes_sent < (seg + 1) * SEGMENT_BYTES) begin
            send_frame(kinds[$urandom_range(2)]);
            if ($urandom_range(99) < 15) begin
               repeat ($urandom_range(3, 1)) begin
                  case ($urandom_range(3))
                     0: send_byte(HDR_A0);
                     1: send_byte(HDR_E0);
                     default: send_byte(8'($urandom));
                  endcase
               end
            end
         end
      end
      settle();
      book.flag_leftovers();
      if (book.mismatches == 0) begin
         $display("[multi_format_frame_deframer_core] OK");
      end else begin
         $display("[multi_format_frame_deframer_core] ERROR");
      end
      $finish;
   end

endmodule

@@ multi_format_frame_deframer_core.f @@
sv/mfd_pkg.sv
sv/mfd_if.sv
sv/mfd_in_stage.sv
sv/mfd_parser.sv
sv/multi_format_frame_deframer_core.sv
sv/mfd_checker.sv
tb/tb_multi_format_frame_deframer_core.sv
